// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker of the section peak normaliser.
// Needs no other file; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent are checked in the same cycle.
`define ASSERT_SAME_CYCLE(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/aspn_pkg.sv =====
// Package of the section peak normaliser: sizes, request and register codes,
// controller command and status structs, and the sample magnitude function.
// Depends on nothing.
`default_nettype none

package aspn_pkg;

    localparam int FRAME_DEPTH    = 4096;
    localparam int SAMPLE_BITS    = 24;
    localparam int FRAC_BITS      = SAMPLE_BITS - 4;
    localparam int ADDR_BITS      = $clog2(FRAME_DEPTH);
    localparam int FRAME_BITS     = 2 * SAMPLE_BITS;
    localparam int INDEX_BITS     = 12;
    localparam int REQ_BITS       = 2;
    localparam int START_BITS     = 12;
    localparam int END_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam int NUM_BITS = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS = SAMPLE_BITS + 1;
    localparam int DIV_BITS = FRAC_BITS + 1;
    localparam int CNT_BITS = $clog2(QUO_BITS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0]        mag_t;

    localparam mag_t Q_ONE = mag_t'(1) << FRAC_BITS;

    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_END    = 2'd2;

    typedef struct packed {
        logic clear_peak;
        logic load_frame;
        logic read_frame;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scale;
        logic div_last;
        logic out_free;
    } status_t;

    function automatic mag_t magnitude(input sample_t v);
        if (v[SAMPLE_BITS-1])
        begin
            return mag_t'(~v) + mag_t'(1);
        end
        return mag_t'(v);
    endfunction

endpackage

`default_nettype wire

// ===== design/aspn_if.sv =====
// Handshake interfaces of the section peak normaliser: request and response.
// Depends on aspn_pkg.
`default_nettype none

interface aspn_req_if;
    logic                              valid;
    logic                              ready;
    logic [aspn_pkg::REQ_BITS-1:0]     req_type;
    logic [aspn_pkg::INDEX_BITS-1:0]   frame_index;
    aspn_pkg::sample_t                 left_in;
    aspn_pkg::sample_t                 right_in;

    modport source (output valid, output req_type, output frame_index,
                    output left_in, output right_in, input ready);
    modport sink (input valid, input req_type, input frame_index,
                  input left_in, input right_in, output ready);
endinterface

interface aspn_rsp_if;
    logic              valid;
    logic              ready;
    aspn_pkg::sample_t left_out;
    aspn_pkg::sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== design/audio_section_peak_normalizer_unit.sv =====
// Top level of the section peak normaliser: joins controller and datapath.
// Depends on aspn_pkg, aspn_if, aspn_ctrl and aspn_datapath.
//
//   Channel  Direction  Signals                                   Transaction
//   req      in         req_type, frame_index, left_in, right_in  valid & ready
//   rsp      out        left_out, right_out                       valid & ready
//   cfg      in         cfg_index, cfg_data                       cfg_we
//
// Clear and load requests do not hold off the request channel and may follow back to back.
// A read passes through a frame store read, the loading of the divider, 25 steps
// of the two-lane restoring divider (one quotient bit per step) and the response
// register when the frame is scaled; a frame returned unchanged skips the divider.
// The next request is taken once the response register has been loaded.
// Reset clears the peak and the configuration; the frame store is not cleared.
// A stalled response holds the read path in its final state until taken.
`default_nettype none

module audio_section_peak_normalizer_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    aspn_req_if.sink                                 req,
    aspn_rsp_if.source                               rsp,
    input  wire logic                                cfg_we,
    input  wire logic [aspn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [aspn_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    aspn_pkg::cmd_t    cmd;
    aspn_pkg::status_t status;
    logic              req_ready;

    aspn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign req.ready = req_ready;

    aspn_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .frame_index (req.frame_index),
        .left_in     (req.left_in),
        .right_in    (req.right_in),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

// ===== design/aspn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module aspn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/aspn_datapath.sv =====
// Datapath of the section peak normaliser: configuration registers, peak
// register, frame store, two-lane restoring divider and response register.
// Depends on aspn_pkg, aspn_if and aspn_ram.
`default_nettype none

module aspn_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire aspn_pkg::cmd_t                      cmd,
    output      aspn_pkg::status_t                   status,
    input  wire logic [aspn_pkg::INDEX_BITS-1:0]     frame_index,
    input  wire aspn_pkg::sample_t                   left_in,
    input  wire aspn_pkg::sample_t                   right_in,
    input  wire logic                                cfg_we,
    input  wire logic [aspn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [aspn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    aspn_rsp_if.source                               rsp
);

    logic                                stereo_reg;
    logic [aspn_pkg::START_BITS-1:0]     start_reg;
    logic [aspn_pkg::END_BITS-1:0]       end_reg;
    aspn_pkg::mag_t                      peak_reg;
    aspn_pkg::mag_t                      peak_next;
    logic                                scale_reg;

    logic [aspn_pkg::ADDR_BITS-1:0]      frame_addr;
    logic [aspn_pkg::END_BITS-1:0]       idx_ext;
    logic                                in_section;
    logic                                scale_now;
    aspn_pkg::mag_t                      mag_l;
    aspn_pkg::mag_t                      mag_r;
    logic [aspn_pkg::FRAME_BITS-1:0]     ram_rdata;
    aspn_pkg::sample_t                   ram_left;
    aspn_pkg::sample_t                   ram_right;

    logic [aspn_pkg::DIV_BITS-1:0]       d_reg;
    logic [aspn_pkg::CNT_BITS-1:0]       cnt_reg;
    logic [aspn_pkg::QUO_BITS-1:0]       num_reg [2];
    logic [aspn_pkg::DIV_BITS-1:0]       rem_reg [2];
    logic [aspn_pkg::QUO_BITS-1:0]       quo_reg [2];
    logic                                ovf_reg [2];
    logic                                neg_reg [2];

    aspn_pkg::sample_t                   lane_sample [2];
    logic [aspn_pkg::NUM_BITS-1:0]       lane_num [2];
    logic [aspn_pkg::DIV_BITS-1:0]       lane_hi [2];
    logic [aspn_pkg::DIV_BITS:0]         lane_shift [2];
    logic                                lane_ge [2];
    logic [aspn_pkg::DIV_BITS-1:0]       lane_rem [2];
    logic [aspn_pkg::QUO_BITS-1:0]       lane_lim [2];
    logic [aspn_pkg::QUO_BITS-1:0]       lane_sat [2];
    aspn_pkg::sample_t                   lane_out [2];

    logic                                rsp_valid_reg;
    aspn_pkg::sample_t                   left_out_reg;
    aspn_pkg::sample_t                   right_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            start_reg  <= '0;
            end_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aspn_pkg::CFG_STEREO: stereo_reg <= cfg_data[0];
                aspn_pkg::CFG_START:  start_reg  <= cfg_data[aspn_pkg::START_BITS-1:0];
                aspn_pkg::CFG_END:    end_reg    <= cfg_data[aspn_pkg::END_BITS-1:0];
                default:              ;
            endcase
        end
    end

    assign frame_addr = aspn_pkg::ADDR_BITS'(frame_index);
    assign idx_ext    = aspn_pkg::END_BITS'(frame_addr);
    assign in_section = (idx_ext >= aspn_pkg::END_BITS'(start_reg)) && (idx_ext < end_reg);
    assign scale_now  = in_section && (peak_reg != '0) && (peak_reg < aspn_pkg::Q_ONE);

    assign mag_l = aspn_pkg::magnitude(left_in);
    assign mag_r = stereo_reg ? aspn_pkg::magnitude(right_in) : '0;

    always_comb
    begin
        peak_next = peak_reg;
        if (cmd.clear_peak)
        begin
            peak_next = '0;
        end
        else if (cmd.load_frame && in_section)
        begin
            if (mag_l > peak_next)
            begin
                peak_next = mag_l;
            end
            if (mag_r > peak_next)
            begin
                peak_next = mag_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_frame)
        begin
            scale_reg <= scale_now;
        end
    end

    aspn_ram #(
        .WIDTH (aspn_pkg::FRAME_BITS),
        .DEPTH (aspn_pkg::FRAME_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (cmd.load_frame),
        .waddr (frame_addr),
        .wdata ({left_in, right_in}),
        .re    (cmd.read_frame),
        .raddr (frame_addr),
        .rdata (ram_rdata)
    );

    assign ram_left  = ram_rdata[aspn_pkg::FRAME_BITS-1:aspn_pkg::SAMPLE_BITS];
    assign ram_right = ram_rdata[aspn_pkg::SAMPLE_BITS-1:0];

    assign lane_sample[0] = ram_left;
    assign lane_sample[1] = ram_right;

    // Each lane divides (magnitude * 2^(FRAC+1) + peak) by twice the peak, which
    // rounds to nearest with ties away from zero. The upper bits of the numerator
    // seed the remainder; if they already reach the divisor the result saturates.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            lane_num[i] = {aspn_pkg::magnitude(lane_sample[i]),
                           {(aspn_pkg::FRAC_BITS + 1){1'b0}}}
                          + aspn_pkg::NUM_BITS'(peak_reg);
            lane_hi[i] = aspn_pkg::DIV_BITS'(
                lane_num[i][aspn_pkg::NUM_BITS-1:aspn_pkg::QUO_BITS]);
            lane_shift[i] = {rem_reg[i], num_reg[i][aspn_pkg::QUO_BITS-1]};
            lane_ge[i] = lane_shift[i] >= {1'b0, d_reg};
            lane_rem[i] = lane_ge[i]
                ? aspn_pkg::DIV_BITS'(lane_shift[i] - {1'b0, d_reg})
                : lane_shift[i][aspn_pkg::DIV_BITS-1:0];
            lane_lim[i] = (aspn_pkg::QUO_BITS'(1) << (aspn_pkg::SAMPLE_BITS - 1))
                          - (neg_reg[i] ? '0 : aspn_pkg::QUO_BITS'(1));
            lane_sat[i] = (ovf_reg[i] || (quo_reg[i] > lane_lim[i])) ? lane_lim[i]
                                                                     : quo_reg[i];
            lane_out[i] = neg_reg[i]
                ? aspn_pkg::sample_t'(-lane_sat[i][aspn_pkg::SAMPLE_BITS-1:0])
                : aspn_pkg::sample_t'(lane_sat[i][aspn_pkg::SAMPLE_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            d_reg   <= {peak_reg[aspn_pkg::FRAC_BITS-1:0], 1'b0};
            cnt_reg <= '0;
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= lane_num[i][aspn_pkg::QUO_BITS-1:0];
                rem_reg[i] <= lane_hi[i];
                quo_reg[i] <= '0;
                ovf_reg[i] <= lane_hi[i] >= {peak_reg[aspn_pkg::FRAC_BITS-1:0], 1'b0};
                neg_reg[i] <= lane_sample[i][aspn_pkg::SAMPLE_BITS-1];
            end
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + aspn_pkg::CNT_BITS'(1);
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= num_reg[i] << 1;
                rem_reg[i] <= lane_rem[i];
                quo_reg[i] <= {quo_reg[i][aspn_pkg::QUO_BITS-2:0], lane_ge[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_out_reg <= scale_reg ? lane_out[0] : ram_left;
            if (!stereo_reg)
            begin
                right_out_reg <= '0;
            end
            else
            begin
                right_out_reg <= scale_reg ? lane_out[1] : ram_right;
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.left_out  = left_out_reg;
    assign rsp.right_out = right_out_reg;

    assign status.scale    = scale_reg;
    assign status.div_last = cnt_reg == aspn_pkg::CNT_BITS'(aspn_pkg::QUO_BITS - 1);
    assign status.out_free = !rsp_valid_reg || rsp.ready;

endmodule

`default_nettype wire

// ===== design/aspn_ctrl.sv =====
// Controller of the section peak normaliser: request decode and the state
// machine that sequences frame reads, division and the response register.
// Depends on aspn_pkg.
`default_nettype none

module aspn_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic [aspn_pkg::REQ_BITS-1:0] req_type,
    output      logic                          req_ready,
    input  wire aspn_pkg::status_t             status,
    output      aspn_pkg::cmd_t                cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_WAIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_type)
                        aspn_pkg::REQ_CLEAR: cmd.clear_peak = 1'b1;
                        aspn_pkg::REQ_LOAD:  cmd.load_frame = 1'b1;
                        aspn_pkg::REQ_READ:
                        begin
                            cmd.read_frame = 1'b1;
                            state_next     = S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                if (status.scale)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/aspn_checker.sv =====
// Port-level checker for the section peak normaliser and its bind statement.
// Depends on aspn_pkg, assert_macros.svh and the top level.
`default_nettype none
`include "assert_macros.svh"

module aspn_prop_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic [aspn_pkg::REQ_BITS-1:0] req_type,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire aspn_pkg::sample_t             left_out,
    input wire aspn_pkg::sample_t             right_out
);

    logic read_taken;
    logic other_taken;

    assign read_taken  = req_valid && req_ready && (req_type == aspn_pkg::REQ_READ);
    assign other_taken = req_valid && req_ready && (req_type != aspn_pkg::REQ_READ);

    // A read occupies the block until its response has been registered.
    `ASSERT_NEXT_CYCLE(a_read_blocks, clk, rst_n, read_taken, !req_ready)

    // Clear and load transactions never stall the request channel.
    `ASSERT_NEXT_CYCLE(a_other_keeps_ready, clk, rst_n, other_taken, req_ready)

    // A new response appears only at the end of a read, while requests are held off.
    `ASSERT_SAME_CYCLE(a_rsp_after_read, clk, rst_n, $rose(rsp_valid), !$past(req_ready))

    `ASSERT_NEXT_CYCLE(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(left_out) && $stable(right_out))

endmodule

bind audio_section_peak_normalizer_unit aspn_prop_checker u_aspn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .left_out  (rsp.left_out),
    .right_out (rsp.right_out)
);

`default_nettype wire
